### src/alp_pkg.sv
`timescale 1ns / 1ps

package alp_pkg;

	localparam int DATA_W = 64;
	localparam int XMAG_W = 31;
	localparam int RAD_W  = 61;
	localparam int DEN_W  = 4;

	// Highest degree accepted; anything above it is reported as bad arguments.
	localparam logic [3:0] L_MAX = 4'd8;

	typedef logic [1:0] status_t;

	localparam status_t ST_OK  = 2'd0;
	localparam status_t ST_BAD = 2'd1;
	localparam status_t ST_SAT = 2'd2;

	localparam logic signed [DATA_W-1:0] Q32_ONE = 64'sh0000_0001_0000_0000;
	localparam logic signed [DATA_W-1:0] MIN64   = 64'sh8000_0000_0000_0000;
	localparam logic signed [DATA_W-1:0] MAX64   = 64'sh7FFF_FFFF_FFFF_FFFF;
	localparam logic signed [31:0]       X_ONE   = 32'sh4000_0000;
	localparam logic signed [31:0]       X_MONE  = 32'shC000_0000;

endpackage

### src/associated_legendre_evaluator_core.sv
`timescale 1ns / 1ps
// Sequence: bad arguments go straight to the output; otherwise the square root and m
// product steps when m > 0, one step for degree m + 1 when l > m, then one recurrence per degree.
// Throughput: one transaction at a time, set by the shared 32x32 multiplier, the
// bit-serial square root and the divider in each step.
// Reset: arst_n clears the sequencer and the output valid; no result is pending.

module associated_legendre_evaluator_core
	import alp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,  // degree[3:0], order[7:4], arg_x[39:8]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,  // poly_value[63:0]
	output logic [1:0]  m_tuser   // status[1:0]
);

	localparam logic [4:0] S_IDLE  = 5'd0;
	localparam logic [4:0] S_SQMUL = 5'd1;
	localparam logic [4:0] S_SQST  = 5'd2;
	localparam logic [4:0] S_SQRT  = 5'd3;
	localparam logic [4:0] S_PMK   = 5'd4;
	localparam logic [4:0] S_AFTER = 5'd5;
	localparam logic [4:0] S_MXA   = 5'd6;
	localparam logic [4:0] S_MXH   = 5'd7;
	localparam logic [4:0] S_MXL   = 5'd8;
	localparam logic [4:0] S_MXS   = 5'd9;
	localparam logic [4:0] S_POST  = 5'd10;
	localparam logic [4:0] S_CHK   = 5'd11;
	localparam logic [4:0] S_REC2  = 5'd12;
	localparam logic [4:0] S_REC3  = 5'd13;
	localparam logic [4:0] S_DVS   = 5'd14;
	localparam logic [4:0] S_DIV   = 5'd15;
	localparam logic [4:0] S_FIN   = 5'd16;

	localparam logic [1:0] PH_PMM = 2'd0;
	localparam logic [1:0] PH_PMP = 2'd1;
	localparam logic [1:0] PH_REC = 2'd2;

	localparam logic [RAD_W-1:0] RAD_ONE  = 61'h1000_0000_0000_0000;
	localparam logic [DATA_W:0]  LIM63    = 65'h0_8000_0000_0000_0000;
	localparam logic [DATA_W-1:0] RND_Q30 = 64'h0000_0000_2000_0000;

	logic [4:0]               state_q;
	logic [4:0]               state_d;
	logic [1:0]               phase_q;
	logic [3:0]               l_q;
	logic [3:0]               m_q;
	logic [3:0]               i_q;
	logic [3:0]               ll_q;
	logic                     x_neg_q;
	logic [XMAG_W-1:0]        ux_q;
	logic [XMAG_W-1:0]        somx2_q;
	logic [XMAG_W-1:0]        xm_q;
	logic signed [DATA_W-1:0] pmm_q;
	logic signed [DATA_W-1:0] pmp_q;
	logic signed [DATA_W-1:0] a_q;
	logic [DATA_W-1:0]        ua_q;
	logic                     neg_q;
	logic [DATA_W-1:0]        prod_q;
	logic [DATA_W-1:0]        hp_q;
	logic signed [DATA_W-1:0] mx_res_q;
	logic signed [DATA_W-1:0] t1_q;
	logic signed [DATA_W-1:0] t2_q;
	logic signed [DATA_W-1:0] diff_q;
	logic signed [DATA_W-1:0] res_q;
	logic                     sat_q;
	logic                     bad_q;
	logic [DATA_W-1:0]        out_data_q;
	status_t                  out_stat_q;
	logic                     out_valid_q;

	logic [3:0]               in_deg;
	logic [3:0]               in_ord;
	logic signed [31:0]       in_x;
	logic                     in_bad;
	logic                     in_acc;
	logic                     out_go;

	logic [31:0]              mul_a;
	logic [31:0]              mul_b;
	logic [DATA_W-1:0]        mul_p;

	logic signed [DATA_W-1:0] mk_a;
	logic [4:0]               mk_k;
	logic signed [69:0]       mk_prod;
	logic signed [DATA_W-1:0] mk_val;
	logic                     mk_sat;

	logic [DATA_W:0]          fm_sum;
	logic signed [DATA_W-1:0] fm_val;
	logic                     fm_sat;

	logic signed [DATA_W-1:0] ng_val;
	logic                     ng_sat;

	logic signed [DATA_W:0]   sb_diff;
	logic signed [DATA_W-1:0] sb_val;
	logic                     sb_sat;

	logic                     sq_start;
	logic                     sq_done;
	logic [XMAG_W-1:0]        sq_root;
	logic                     dv_start;
	logic                     dv_done;
	logic signed [DATA_W-1:0] dv_quot;

	assign in_deg = s_tdata[3:0];
	assign in_ord = s_tdata[7:4];
	assign in_x   = $signed(s_tdata[39:8]);
	assign in_bad = (in_ord > in_deg) || (in_deg > L_MAX) || (in_x > X_ONE) || (in_x < X_MONE);
	assign in_acc = s_tvalid && s_tready;
	assign out_go = (state_q == S_FIN) && (!out_valid_q || m_tready);

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_stat_q;

	// Shared multiplier: x squared for the radicand, then the two halves of every P*x.
	always_comb begin
		unique case (state_q)
			S_MXH: begin
				mul_a = ua_q[63:32];
				mul_b = {1'b0, xm_q};
			end
			S_MXL: begin
				mul_a = ua_q[31:0];
				mul_b = {1'b0, xm_q};
			end
			default: begin
				mul_a = {1'b0, ux_q};
				mul_b = {1'b0, ux_q};
			end
		endcase
	end
	assign mul_p = mul_a * mul_b;

	// Multiplication by a small integer factor, clamped to the 64-bit range.
	always_comb begin
		unique case (state_q)
			S_PMK: begin
				mk_a = pmm_q;
				mk_k = 5'({i_q, 1'b0}) - 5'd1;
			end
			S_POST: begin
				mk_a = mx_res_q;
				mk_k = (phase_q == PH_PMP) ? {m_q, 1'b1} : 5'({ll_q, 1'b0}) - 5'd1;
			end
			default: begin
				mk_a = pmm_q;
				mk_k = 5'(ll_q) + 5'(m_q) - 5'd1;
			end
		endcase
	end
	assign mk_prod = 70'(mk_a) * 70'($signed({1'b0, mk_k}));
	assign mk_sat  = (mk_prod[69:63] != {7{mk_prod[69]}});
	assign mk_val  = mk_sat ? (mk_prod[69] ? MIN64 : MAX64) : mk_prod[63:0];

	// Rounded P*x magnitude from the two partial products, then the sign.
	assign fm_sum = {hp_q[62:0], 2'b00} + 65'((prod_q + RND_Q30) >> 30);
	always_comb begin
		if (neg_q) begin
			fm_sat = (fm_sum > LIM63);
			fm_val = fm_sat ? MIN64 : 64'(-fm_sum);
		end else begin
			fm_sat = (fm_sum >= LIM63);
			fm_val = fm_sat ? MAX64 : fm_sum[63:0];
		end
	end

	assign ng_sat = (mx_res_q == MIN64);
	assign ng_val = ng_sat ? MAX64 : -mx_res_q;

	assign sb_diff = {t1_q[63], t1_q} - {t2_q[63], t2_q};
	assign sb_sat  = (sb_diff[64] != sb_diff[63]);
	assign sb_val  = sb_sat ? (sb_diff[64] ? MIN64 : MAX64) : sb_diff[63:0];

	assign sq_start = (state_q == S_SQST);
	assign dv_start = (state_q == S_DVS);

	alp_isqrt u_isqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (sq_start),
		.rad    (RAD_ONE - prod_q[RAD_W-1:0]),
		.done   (sq_done),
		.root   (sq_root)
	);

	alp_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (dv_start),
		.num    (diff_q),
		.den    (ll_q - m_q),
		.done   (dv_done),
		.quot   (dv_quot)
	);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_acc) begin
					if (in_bad) begin
						state_d = S_FIN;
					end else if (in_ord == 4'd0) begin
						state_d = S_AFTER;
					end else begin
						state_d = S_SQMUL;
					end
				end
			end
			S_SQMUL: state_d = S_SQST;
			S_SQST:  state_d = S_SQRT;
			S_SQRT: begin
				if (sq_done) begin
					state_d = S_PMK;
				end
			end
			S_PMK:   state_d = S_MXA;
			S_AFTER: state_d = (l_q == m_q) ? S_FIN : S_MXA;
			S_MXA:   state_d = S_MXH;
			S_MXH:   state_d = S_MXL;
			S_MXL:   state_d = S_MXS;
			S_MXS:   state_d = S_POST;
			S_POST: begin
				case (phase_q)
					PH_PMM:  state_d = (i_q == m_q) ? S_AFTER : S_PMK;
					PH_PMP:  state_d = S_CHK;
					default: state_d = S_REC2;
				endcase
			end
			S_CHK:  state_d = (ll_q > l_q) ? S_FIN : S_MXA;
			S_REC2: state_d = S_REC3;
			S_REC3: state_d = S_DVS;
			S_DVS:  state_d = S_DIV;
			S_DIV: begin
				if (dv_done) begin
					state_d = S_CHK;
				end
			end
			S_FIN: begin
				if (out_go) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_go) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (in_acc) begin
					l_q     <= in_deg;
					m_q     <= in_ord;
					x_neg_q <= in_x[31];
					ux_q    <= in_x[31] ? 31'(-in_x) : in_x[30:0];
					bad_q   <= in_bad;
					sat_q   <= 1'b0;
					pmm_q   <= Q32_ONE;
					i_q     <= 4'd1;
					res_q   <= '0;
				end
			end
			S_SQMUL: prod_q <= mul_p;
			S_SQST: ;
			S_SQRT: begin
				if (sq_done) begin
					somx2_q <= sq_root;
				end
			end
			S_PMK: begin
				a_q     <= mk_val;
				sat_q   <= sat_q | mk_sat;
				phase_q <= PH_PMM;
			end
			S_AFTER: begin
				res_q   <= pmm_q;
				a_q     <= pmm_q;
				phase_q <= PH_PMP;
			end
			S_MXA: begin
				ua_q  <= a_q[63] ? 64'(-a_q) : 64'(a_q);
				neg_q <= a_q[63] ^ ((phase_q != PH_PMM) && x_neg_q);
				xm_q  <= (phase_q == PH_PMM) ? somx2_q : ux_q;
			end
			S_MXH: prod_q <= mul_p;
			S_MXL: begin
				hp_q   <= prod_q;
				prod_q <= mul_p;
			end
			S_MXS: begin
				mx_res_q <= fm_val;
				sat_q    <= sat_q | fm_sat;
			end
			S_POST: begin
				case (phase_q)
					PH_PMM: begin
						pmm_q <= ng_val;
						sat_q <= sat_q | ng_sat;
						i_q   <= i_q + 4'd1;
					end
					PH_PMP: begin
						pmp_q <= mk_val;
						sat_q <= sat_q | mk_sat;
						ll_q  <= m_q + 4'd2;
					end
					default: begin
						t1_q  <= mk_val;
						sat_q <= sat_q | mk_sat;
					end
				endcase
			end
			S_CHK: begin
				res_q   <= pmp_q;
				a_q     <= pmp_q;
				phase_q <= PH_REC;
			end
			S_REC2: begin
				t2_q  <= mk_val;
				sat_q <= sat_q | mk_sat;
			end
			S_REC3: begin
				diff_q <= sb_val;
				sat_q  <= sat_q | sb_sat;
			end
			S_DVS: ;
			S_DIV: begin
				if (dv_done) begin
					pmm_q <= pmp_q;
					pmp_q <= dv_quot;
					ll_q  <= ll_q + 4'd1;
				end
			end
			S_FIN: begin
				if (out_go) begin
					out_data_q <= res_q;
					out_stat_q <= bad_q ? ST_BAD : (sat_q ? ST_SAT : ST_OK);
				end
			end
			default: ;
		endcase
	end

`ifndef SYNTH
	// Only one transaction is in the sequencer at a time.
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("input taken while a transaction is in progress");

	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && (m_tuser == ST_BAD)) |-> (m_tdata == 64'd0))
		else $error("bad-argument result is not zero");

	a_sq_done: assert property (@(posedge clk) disable iff (!arst_n)
		sq_done |-> (state_q == S_SQRT))
		else $error("square root finished outside its wait state");

	a_dv_done: assert property (@(posedge clk) disable iff (!arst_n)
		dv_done |-> (state_q == S_DIV))
		else $error("divider finished outside its wait state");
`endif

endmodule

### src/alp_isqrt.sv
`timescale 1ns / 1ps

module alp_isqrt
	import alp_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [RAD_W-1:0]  rad,
	output logic              done,
	output logic [XMAG_W-1:0] root
);

	localparam logic [RAD_W-1:0] TOP_BIT = 61'h1000_0000_0000_0000;

	logic              run_q;
	logic              done_q;
	logic [RAD_W-1:0]  v_q;
	logic [RAD_W:0]    r_q;
	logic [RAD_W-1:0]  bit_q;
	logic [RAD_W:0]    trial;
	logic              fits;

	assign trial = r_q + {1'b0, bit_q};
	assign fits  = {1'b0, v_q} >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
			end else if (run_q && bit_q[0]) begin
				run_q  <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	// One result bit per cycle, 31 bits for the full radicand.
	always_ff @(posedge clk) begin
		if (start) begin
			v_q   <= rad;
			r_q   <= '0;
			bit_q <= TOP_BIT;
		end else if (run_q) begin
			if (fits) begin
				v_q <= v_q - trial[RAD_W-1:0];
				r_q <= (r_q >> 1) + {1'b0, bit_q};
			end else begin
				r_q <= r_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

	assign done = done_q;
	assign root = r_q[XMAG_W-1:0];

endmodule

### src/alp_div.sv
`timescale 1ns / 1ps

module alp_div
	import alp_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic signed [DATA_W-1:0] num,
	input  logic [DEN_W-1:0]         den,
	output logic                     done,
	output logic signed [DATA_W-1:0] quot
);

	logic                     run_q;
	logic                     fin_q;
	logic                     done_q;
	logic [2:0]               cnt_q;
	logic                     neg_q;
	logic [DEN_W-1:0]         den_q;
	logic [DATA_W-1:0]        dvd_q;
	logic [DEN_W-1:0]         rem_q;
	logic signed [DATA_W-1:0] quot_q;
	logic [DATA_W-1:0]        base;
	logic [DATA_W-1:0]        addend;
	logic [DATA_W-1:0]        dvd_n;
	logic [DEN_W-1:0]         rem_n;
	logic [DEN_W:0]           part;

	// Magnitude plus half the divisor in one add, so that the quotient rounds half away.
	assign base   = num[DATA_W-1] ? ~num : num;
	assign addend = num[DATA_W-1] ? 64'(den >> 1) + 64'd1 : 64'(den >> 1);

	// Eight quotient bits a cycle; the remainder stays below the divisor.
	always_comb begin
		dvd_n = dvd_q;
		rem_n = rem_q;
		part  = '0;
		for (int j = 0; j < 8; j++) begin
			part  = {rem_n, dvd_n[DATA_W-1]};
			dvd_n = dvd_n << 1;
			if (part >= {1'b0, den_q}) begin
				rem_n    = 4'(part - {1'b0, den_q});
				dvd_n[0] = 1'b1;
			end else begin
				rem_n = part[DEN_W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			fin_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= fin_q;
			fin_q  <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 3'd1;
				if (cnt_q == 3'd7) begin
					run_q <= 1'b0;
					fin_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= base + addend;
			rem_q <= '0;
			neg_q <= num[DATA_W-1];
			den_q <= den;
		end else if (run_q) begin
			dvd_q <= dvd_n;
			rem_q <= rem_n;
		end
		if (fin_q) begin
			quot_q <= neg_q ? -$signed(dvd_q) : $signed(dvd_q);
		end
	end

	assign done = done_q;
	assign quot = quot_q;

endmodule
